>>> design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and constants used by the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int NUM_PAGES  = 1024;
	localparam int NUM_ORDERS = 6;
	localparam int PAGE_W     = 10;
	localparam int LINK_W     = 11;
	localparam int ORDER_W    = 3;
	localparam int COUNT_W    = 11;
	localparam int PAIR_ROWS  = NUM_PAGES / 2;
	localparam int PAIR_AW    = $clog2(PAIR_ROWS);

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_PAGES);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_MEMORY = 2'd1;
	localparam logic [1:0] ST_BAD_ORDER = 2'd2;

	typedef struct packed {
		logic               opcode;
		logic [ORDER_W-1:0] order;
		logic [PAGE_W-1:0]  page_number;
		logic               urgent;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [PAGE_W-1:0]  result_page;
		logic [COUNT_W-1:0] free_total;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ULINK,
		S_FCHK,
		S_FFLIP,
		S_PUSH1,
		S_PUSH2
	} state_t;

endpackage

>>> design/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy allocator over 1024 pages and six block orders.
// ----------------------------------------------------------------------------
// Pulse start while busy is low; the beat is answered by a one-cycle done
// strobe that cannot be held off. Free lists are linked through two link
// memories and the pair bits sit in a 512-row memory, one bit per order, so
// every level costs memory read-modify-write turns: an allocate splits at
// most five levels and a free merges at most five levels. A refused
// allocate, a bad order or a free that lies beyond memory is answered in
// the cycle after it is taken. After reset the pair memory is cleared one
// row a cycle, so busy stays high until all 512 rows are cleared; register
// writes are taken during that pass.
module buddy_page_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bpa_pkg::cmd_t       cmd,
	output logic                done,
	output bpa_pkg::rsp_t       result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int NO = bpa_pkg::NUM_ORDERS;
	localparam int PW = bpa_pkg::PAGE_W;
	localparam int LW = bpa_pkg::LINK_W;
	localparam int OW = bpa_pkg::ORDER_W;
	localparam int CW = bpa_pkg::COUNT_W;
	localparam int AW = bpa_pkg::PAIR_AW;

	bpa_pkg::state_t state_q, state_d;

	logic [CW-1:0] reserve_q;
	logic [CW-1:0] fc_q, fc_d;
	logic [LW-1:0] heads_q [NO];
	logic [LW-1:0] heads_d [NO];
	logic [OW-1:0] k_q, k_d, ord_q, ord_d;
	logic [PW-1:0] p_q, p_d;
	logic [LW-1:0] n_q, n_d;
	logic          flip_q, flip_d, opc_q, opc_d;
	logic [AW-1:0] pa_q, pa_d, clr_q, clr_d;
	logic          done_q, done_d;
	bpa_pkg::rsp_t res_q, res_d;

	// memory ports
	logic          nx_we, pv_we, pr_we;
	logic [PW-1:0] nx_wa, pv_wa, lk_ra;
	logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
	logic [AW-1:0] pr_wa, pr_ra;
	logic [NO-1:0] pr_wd, pr_rd;

	bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::NUM_PAGES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(lk_ra), .rdata(nx_rd)
	);
	bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::NUM_PAGES)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(lk_ra), .rdata(pv_rd)
	);
	bpa_ram #(.WIDTH(NO), .DEPTH(bpa_pkg::PAIR_ROWS)) u_pair (
		.clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd)
	);

	// configuration port
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32-CW){1'b0}}, reserve_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserve_q <= CW'(48);
		end else if (psel && penable && pwrite && !paddr[2]) begin
			reserve_q <= pwdata[CW-1:0];
		end
	end

	assign busy   = (state_q != bpa_pkg::S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	function automatic logic lk_ok(input logic [LW-1:0] v);
		return !v[LW-1];
	endfunction

	function automatic logic [AW-1:0] pair_row(input logic [PW-1:0] p, input logic [OW-1:0] k);
		logic [PW-1:0] s;
		s = p >> (k + OW'(1));
		return s[AW-1:0];
	endfunction

	logic [OW-1:0]   kf;
	logic            kf_hit;
	logic [PW-1:0]   size_k, up;
	logic [CW:0]     need, sum, up_end;
	logic [NO-1:0]   bit_k;
	logic [PW-1:0]   fp;

	always_comb begin
		kf     = '0;
		kf_hit = 1'b0;
		for (int i = NO - 1; i >= 0; i--) begin
			if (OW'(i) >= cmd.order && lk_ok(heads_q[i])) begin
				kf     = OW'(i);
				kf_hit = 1'b1;
			end
		end
	end

	always_comb begin
		logic [LW-1:0] n, b;

		state_d = state_q;
		fc_d    = fc_q;
		heads_d = heads_q;
		k_d     = k_q;
		ord_d   = ord_q;
		p_d     = p_q;
		n_d     = n_q;
		flip_d  = flip_q;
		opc_d   = opc_q;
		pa_d    = pa_q;
		clr_d   = clr_q;
		done_d  = 1'b0;
		res_d   = res_q;

		nx_we = 1'b0; nx_wa = p_q; nx_wd = bpa_pkg::NIL_LINK;
		pv_we = 1'b0; pv_wa = p_q; pv_wd = bpa_pkg::NIL_LINK;
		pr_we = 1'b0; pr_wa = pa_q;
		lk_ra = p_q;
		pr_ra = pa_q;

		n = nx_rd;
		b = pv_rd;

		bit_k  = NO'(1) << k_q;
		size_k = PW'(1) << k_q;
		up     = p_q & ~((size_k << 1) - PW'(1));
		up_end = (CW+1)'(up) + ((CW+1)'(size_k) << 1);
		need   = (CW+1)'(1) << cmd.order;
		sum    = (CW+1)'(fc_q) + need;
		fp     = cmd.page_number & ~PW'(need[PW-1:0] - PW'(1));
		pr_wd  = pr_rd ^ bit_k;

		case (state_q)
			bpa_pkg::S_CLEAR: begin
				pr_we = 1'b1;
				pr_wa = clr_q;
				pr_wd = '0;
				clr_d = clr_q + AW'(1);
				if (&clr_q) begin
					state_d = bpa_pkg::S_IDLE;
				end
			end
			bpa_pkg::S_IDLE: begin
				if (start) begin
					opc_d = cmd.opcode;
					ord_d = cmd.order;
					res_d.status      = bpa_pkg::ST_OK;
					res_d.result_page = '0;
					res_d.free_total  = fc_q;
					if (cmd.order >= OW'(NO)) begin
						res_d.status = bpa_pkg::ST_BAD_ORDER;
						done_d = 1'b1;
					end else if (cmd.opcode == bpa_pkg::OP_ALLOC) begin
						if ((!cmd.urgent && !(fc_q > reserve_q)) || !kf_hit) begin
							res_d.status = bpa_pkg::ST_NO_MEMORY;
							done_d = 1'b1;
						end else begin
							// take the head block, read its links and pair row
							k_d   = kf;
							p_d   = heads_q[kf][PW-1:0];
							lk_ra = heads_q[kf][PW-1:0];
							pa_d  = pair_row(heads_q[kf][PW-1:0], kf);
							pr_ra = pair_row(heads_q[kf][PW-1:0], kf);
							fc_d  = ((CW+1)'(fc_q) >= need) ? fc_q - need[CW-1:0] : '0;
							state_d = bpa_pkg::S_ULINK;
						end
					end else begin
						if ((CW+1)'(fp) + need <= (CW+1)'(bpa_pkg::NUM_PAGES)) begin
							fc_d = (sum > (CW+1)'(bpa_pkg::NUM_PAGES)) ?
								CW'(bpa_pkg::NUM_PAGES) : sum[CW-1:0];
							k_d  = cmd.order;
							p_d  = fp;
							state_d = bpa_pkg::S_FCHK;
						end else begin
							done_d = 1'b1;
						end
					end
				end
			end
			bpa_pkg::S_ULINK: begin
				if (lk_ok(n)) begin
					pv_we = 1'b1;
					pv_wa = n[PW-1:0];
					pv_wd = b;
				end
				if (lk_ok(b)) begin
					nx_we = 1'b1;
					nx_wa = b[PW-1:0];
					nx_wd = n;
				end else begin
					heads_d[k_q] = lk_ok(n) ? n : bpa_pkg::NIL_LINK;
				end
				if (opc_q == bpa_pkg::OP_ALLOC) begin
					pr_we = 1'b1;
					if (k_q > ord_q) begin
						k_d    = k_q - OW'(1);
						flip_d = 1'b1;
						state_d = bpa_pkg::S_PUSH1;
					end else begin
						res_d.result_page = p_q;
						res_d.free_total  = fc_q;
						done_d  = 1'b1;
						state_d = bpa_pkg::S_IDLE;
					end
				end else begin
					// buddy is off its list: move up one order
					k_d = k_q + OW'(1);
					p_d = up;
					state_d = bpa_pkg::S_FCHK;
				end
			end
			bpa_pkg::S_FCHK: begin
				if ((k_q + OW'(1) < OW'(NO)) && (up_end <= (CW+1)'(bpa_pkg::NUM_PAGES))) begin
					pa_d  = pair_row(p_q, k_q);
					pr_ra = pair_row(p_q, k_q);
					state_d = bpa_pkg::S_FFLIP;
				end else begin
					flip_d  = 1'b0;
					state_d = bpa_pkg::S_PUSH1;
				end
			end
			bpa_pkg::S_FFLIP: begin
				pr_we = 1'b1;
				if ((pr_rd & bit_k) != '0) begin
					lk_ra = p_q ^ size_k;
					state_d = bpa_pkg::S_ULINK;
				end else begin
					flip_d  = 1'b0;
					state_d = bpa_pkg::S_PUSH1;
				end
			end
			bpa_pkg::S_PUSH1: begin
				n_d   = heads_q[k_q];
				nx_we = 1'b1;
				nx_wd = heads_q[k_q];
				pv_we = 1'b1;
				pv_wd = bpa_pkg::NIL_LINK;
				heads_d[k_q] = LW'(p_q);
				pa_d  = pair_row(p_q, k_q);
				pr_ra = pair_row(p_q, k_q);
				state_d = bpa_pkg::S_PUSH2;
			end
			bpa_pkg::S_PUSH2: begin
				if (lk_ok(n_q)) begin
					pv_we = 1'b1;
					pv_wa = n_q[PW-1:0];
					pv_wd = LW'(p_q);
				end
				pr_we = flip_q;
				if (opc_q == bpa_pkg::OP_ALLOC) begin
					// keep the upper half, the lower half stays listed
					p_d = p_q + size_k;
					if (k_q > ord_q) begin
						k_d = k_q - OW'(1);
						state_d = bpa_pkg::S_PUSH1;
					end else begin
						res_d.result_page = p_q + size_k;
						res_d.free_total  = fc_q;
						done_d  = 1'b1;
						state_d = bpa_pkg::S_IDLE;
					end
				end else begin
					res_d.free_total = fc_q;
					done_d  = 1'b1;
					state_d = bpa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q   <= '0;
			clr_q  <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < NO; i++) begin
				heads_q[i] <= bpa_pkg::NIL_LINK;
			end
		end else begin
			fc_q    <= fc_d;
			clr_q   <= clr_d;
			done_q  <= done_d;
			heads_q <= heads_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q    <= k_d;
		ord_q  <= ord_d;
		p_q    <= p_d;
		n_q    <= n_d;
		flip_q <= flip_d;
		opc_q  <= opc_d;
		pa_q   <= pa_d;
		res_q  <= res_d;
	end

endmodule

>>> design/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic RAM, one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
